@@ rtl/core/qau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Shared widths, opcodes, pipeline sideband type and the saturation helper.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int FRAC_BITS = 28;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int SHIFT_W   = SUM_W - FRAC_BITS;
    localparam int TR_W      = FRAC_BITS + 3;
    localparam int RAD_W     = SUM_W;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int TOL_W     = 29;
    localparam int OP_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_MUL   = 3'd0,
        OP_CONJ  = 3'd1,
        OP_SCALE = 3'd2,
        OP_NORM  = 3'd3,
        OP_TRACE = 3'd4,
        OP_DIST  = 3'd5,
        OP_UNIT  = 3'd6
    } op_e;

    // Hamilton product sign pattern per lane, bit k set means subtract term k
    localparam logic [3:0][3:0] MUL_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

    typedef struct packed {
        logic                     valid;
        logic [OP_W-1:0]          op;
        logic [3:0][WORD_W-1:0]   r;
        logic [WORD_W-1:0]        scal;
        logic                     ov;
        logic                     tr_ok;
    } side_t;

    // Saturate to a signed word; bit WORD_W of the result is the overflow flag
    function automatic logic [WORD_W:0] sat_word(input logic signed [SHIFT_W-1:0] v);
        logic signed [SHIFT_W-1:0] max_v;
        logic signed [SHIFT_W-1:0] min_v;
        max_v = {{(SHIFT_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
        min_v = {{(SHIFT_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
        if (v > max_v)
            sat_word = {1'b1, max_v[WORD_W-1:0]};
        else if (v < min_v)
            sat_word = {1'b1, min_v[WORD_W-1:0]};
        else
            sat_word = {1'b0, v[WORD_W-1:0]};
    endfunction

endpackage

@@ rtl/core/quaternion_arithmetic_unit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Q4.28 quaternion ALU: Hamilton product, conjugate, scale, norm, trace,
// SU(2) distance and unit-norm test, fully pipelined.
// ----------------------------------------------------------------------------
// The unit takes one item per clock: busy is always low, so every cycle with
// start high is accepted. Each item yields one result on the done strobe, in
// order; results cannot be held off and must be captured in the cycle done is
// high. The path runs through the product lanes (2 stages), the merge stage
// (2), the 33-stage bit-per-stage square root used by norm, distance and unit
// check, and the output register. Every opcode travels the same path, so
// latency does not depend on the opcode.
// unit_tolerance may be written at any time the pipeline is empty.
module quaternion_arithmetic_unit_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [qau_pkg::OP_W-1:0]      req_type,
    input  logic [qau_pkg::WORD_W-1:0]    p_real,
    input  logic [qau_pkg::WORD_W-1:0]    p_i,
    input  logic [qau_pkg::WORD_W-1:0]    p_j,
    input  logic [qau_pkg::WORD_W-1:0]    p_k,
    input  logic [qau_pkg::WORD_W-1:0]    q_real,
    input  logic [qau_pkg::WORD_W-1:0]    q_i,
    input  logic [qau_pkg::WORD_W-1:0]    q_j,
    input  logic [qau_pkg::WORD_W-1:0]    q_k,
    input  logic [qau_pkg::WORD_W-1:0]    scale_factor,
    input  logic                          unit_tolerance_we,
    input  logic [qau_pkg::TOL_W-1:0]     unit_tolerance,
    output logic                          done,
    output logic [qau_pkg::WORD_W-1:0]    r_real,
    output logic [qau_pkg::WORD_W-1:0]    r_i,
    output logic [qau_pkg::WORD_W-1:0]    r_j,
    output logic [qau_pkg::WORD_W-1:0]    r_k,
    output logic [qau_pkg::WORD_W-1:0]    r_scalar,
    output logic                          is_unit,
    output logic                          overflow
);
    import qau_pkg::*;

    localparam logic [ROOT_W-1:0] ONE = ROOT_W'(1) << FRAC_BITS;

    logic [3:0][WORD_W-1:0]       p;
    logic [3:0][WORD_W-1:0]       q;
    logic [3:0][3:0][WORD_W-1:0]  lx;
    logic [3:0][3:0][WORD_W-1:0]  ly;
    logic [3:0][3:0]              lneg;
    logic [3:0][SUM_W-1:0]        sums;
    logic                         v1_reg, v2_reg;
    logic [OP_W-1:0]              op1_reg, op2_reg;
    logic [3:0][WORD_W-1:0]       p1_reg, p2_reg;
    side_t                        side_m;
    logic [RAD_W-1:0]             rad_m;
    side_t                        side_q;
    logic [ROOT_W-1:0]            root_q;
    logic [TOL_W-1:0]             tol_reg;
    logic [ROOT_W-1:0]            diff;
    logic [WORD_W:0]              st;
    logic [WORD_W-1:0]            scal_next;
    logic                         unit_next;
    logic                         ov_next;
    logic                         done_reg;
    logic [3:0][WORD_W-1:0]       r_reg;
    logic [WORD_W-1:0]            scal_reg;
    logic                         unit_reg;
    logic                         ov_reg;

    assign busy = 1'b0;
    assign p    = {p_k, p_j, p_i, p_real};
    assign q    = {q_k, q_j, q_i, q_real};

    // Route operands to the lanes per opcode
    always_comb
    begin
        lx   = '0;
        ly   = '0;
        lneg = '0;
        case (req_type) inside
            OP_MUL:
            begin
                for (int l = 0; l < 4; l++)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        lx[l][k] = p[k];
                        ly[l][k] = q[2'(l) ^ 2'(k)];
                    end
                    lneg[l] = MUL_NEG[l];
                end
            end
            OP_SCALE:
            begin
                for (int l = 0; l < 4; l++)
                begin
                    lx[l][0] = p[l];
                    ly[l][0] = scale_factor;
                end
            end
            OP_NORM, OP_UNIT:
            begin
                lx[0] = p;
                ly[0] = p;
            end
            OP_DIST:
            begin
                lx[0] = p;
                ly[0] = q;
            end
            default:
            begin
                lneg = '0;
            end
        endcase
    end

    genvar l;
    generate
        for (l = 0; l < 4; l++)
        begin : g_lane
            qau_lane u_lane (
                .clk (clk),
                .x   (lx[l]),
                .y   (ly[l]),
                .neg (lneg[l]),
                .sum (sums[l])
            );
        end
    endgenerate

    // Hold opcode and p alongside the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg <= req_type;
        p1_reg  <= p;
        op2_reg <= op1_reg;
        p2_reg  <= p1_reg;
    end

    qau_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v2_reg),
        .op       (op2_reg),
        .p        (p2_reg),
        .sums     (sums),
        .side     (side_m),
        .rad      (rad_m)
    );

    qau_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (side_m),
        .rad      (rad_m),
        .side_out (side_q),
        .root     (root_q)
    );

    // Finish norm, distance and unit check from the root
    always_comb
    begin
        scal_next = side_q.scal;
        unit_next = 1'b0;
        ov_next   = side_q.ov;
        diff      = (root_q >= ONE) ? root_q - ONE : ONE - root_q;
        st        = sat_word(SHIFT_W'(root_q));
        case (side_q.op)
            OP_NORM:
            begin
                scal_next = st[WORD_W-1:0];
                ov_next   = st[WORD_W];
            end
            OP_DIST:
            begin
                scal_next = side_q.tr_ok ? root_q[WORD_W-1:0] : '0;
            end
            OP_UNIT:
            begin
                unit_next = diff < ROOT_W'(tol_reg);
            end
            default:
            begin
                unit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg  <= TOL_W'(1);
            done_reg <= 1'b0;
        end
        else
        begin
            if (unit_tolerance_we)
            begin
                tol_reg <= unit_tolerance;
            end
            done_reg <= side_q.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= side_q.r;
        scal_reg <= scal_next;
        unit_reg <= unit_next;
        ov_reg   <= ov_next;
    end

    assign done     = done_reg;
    assign r_real   = r_reg[0];
    assign r_i      = r_reg[1];
    assign r_j      = r_reg[2];
    assign r_k      = r_reg[3];
    assign r_scalar = scal_reg;
    assign is_unit  = unit_reg;
    assign overflow = ov_reg;

    // A root leaving the pipeline always produces a result next cycle
    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        side_q.valid |=> done_reg)
        else $error("result strobe missing after root stage");

    // A unit check result carries no scalar and no overflow
    a_unit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && unit_reg) |-> (scal_reg == '0) && !ov_reg && (r_reg == '0))
        else $error("unit check result has stray fields");

    // A distance with out-of-range trace comes out as zero without overflow
    a_dist_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (side_q.valid && (side_q.op == OP_DIST) && !side_q.tr_ok)
            |=> (scal_reg == '0) && !ov_reg)
        else $error("clamped distance is not zero");

endmodule

@@ rtl/core/qau_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion unit product lane
// Four signed products in one stage, exact signed sum of them in the next.
// ----------------------------------------------------------------------------
module qau_lane (
    input  logic                                  clk,
    input  logic [3:0][qau_pkg::WORD_W-1:0]       x,
    input  logic [3:0][qau_pkg::WORD_W-1:0]       y,
    input  logic [3:0]                            neg,
    output logic [qau_pkg::SUM_W-1:0]             sum
);
    import qau_pkg::*;

    logic signed [PROD_W-1:0] prod [4];
    logic [3:0][PROD_W-1:0]   prod_reg;
    logic [3:0]               neg_reg;
    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  term;
    logic [SUM_W-1:0]         sum_reg;

    // Form the four products at full width
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod[k] = $signed(x[k]) * $signed(y[k]);
        end
    end

    // Add or subtract each product per the sign mask
    always_comb
    begin
        acc  = '0;
        term = '0;
        for (int k = 0; k < 4; k++)
        begin
            term = {{(SUM_W-PROD_W){prod_reg[k][PROD_W-1]}}, prod_reg[k]};
            acc  = neg_reg[k] ? acc - term : acc + term;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod_reg[k] <= prod[k];
        end
        neg_reg <= neg;
        sum_reg <= acc;
    end

    assign sum = sum_reg;

endmodule

@@ rtl/core/qau_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion unit merge stage
// Floor-shifts and saturates the lane sums, and builds the square-root radicand.
// ----------------------------------------------------------------------------
module qau_merge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [qau_pkg::OP_W-1:0]              op,
    input  logic [3:0][qau_pkg::WORD_W-1:0]       p,
    input  logic [3:0][qau_pkg::SUM_W-1:0]        sums,
    output qau_pkg::side_t                        side,
    output logic [qau_pkg::RAD_W-1:0]             rad
);
    import qau_pkg::*;

    localparam logic signed [SHIFT_W:0] TR_MAX   = (SHIFT_W+1)'(1) << (FRAC_BITS + 1);
    localparam logic signed [SHIFT_W:0] TR_MIN   = -TR_MAX;
    localparam logic [RAD_W-1:0]        RAD_FOUR = RAD_W'(1) << (2 * FRAC_BITS + 2);

    side_t                     side_next;
    side_t                     side_c_reg;
    side_t                     side_d_reg;
    logic signed [SHIFT_W-1:0] sh [4];
    logic signed [SHIFT_W:0]   tr_full;
    logic [WORD_W:0]           st;
    logic [TR_W-1:0]           tr_next;
    logic [TR_W-1:0]           tr_reg;
    logic [RAD_W-1:0]          norm_next;
    logic [RAD_W-1:0]          norm_reg;
    logic signed [2*TR_W-1:0]  sq;
    logic [RAD_W-1:0]          rad_next;
    logic [RAD_W-1:0]          rad_reg;

    // Floor-shift the sums and select the per-opcode results
    always_comb
    begin
        side_next       = '0;
        side_next.valid = in_valid;
        side_next.op    = op;
        st              = '0;
        for (int k = 0; k < 4; k++)
        begin
            sh[k] = $signed(sums[k][SUM_W-1:FRAC_BITS]);
        end
        tr_full   = {sh[0], 1'b0};
        tr_next   = tr_full[TR_W-1:0];
        norm_next = {1'b0, sums[0][SUM_W-2:0]};
        case (op) inside
            OP_MUL, OP_SCALE:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    st             = sat_word(sh[k]);
                    side_next.r[k] = st[WORD_W-1:0];
                    side_next.ov   = side_next.ov | st[WORD_W];
                end
            end
            OP_CONJ:
            begin
                side_next.r[0] = p[0];
                for (int k = 1; k < 4; k++)
                begin
                    st             = sat_word(-SHIFT_W'($signed(p[k])));
                    side_next.r[k] = st[WORD_W-1:0];
                    side_next.ov   = side_next.ov | st[WORD_W];
                end
            end
            OP_TRACE:
            begin
                st             = sat_word(SHIFT_W'($signed(p[0])) <<< 1);
                side_next.scal = st[WORD_W-1:0];
                side_next.ov   = st[WORD_W];
            end
            OP_DIST:
            begin
                side_next.tr_ok = (tr_full <= TR_MAX) && (tr_full >= TR_MIN);
            end
            default:
            begin
                side_next.ov = 1'b0;
            end
        endcase
    end

    // Square the trace for the distance, else pass the norm sum through
    assign sq       = $signed(tr_reg) * $signed(tr_reg);
    assign rad_next = (side_c_reg.op == OP_DIST) ? RAD_FOUR - RAD_W'($unsigned(sq)) : norm_reg;

    // Advance the sideband through both merge stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_c_reg <= '0;
            side_d_reg <= '0;
        end
        else
        begin
            side_c_reg <= side_next;
            side_d_reg <= side_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tr_reg   <= tr_next;
        norm_reg <= norm_next;
        rad_reg  <= rad_next;
    end

    assign side = side_d_reg;
    assign rad  = rad_reg;

endmodule

@@ rtl/core/qau_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion unit square root pipeline
// Digit-by-digit integer root, one root bit per stage, sideband carried along.
// ----------------------------------------------------------------------------
module qau_isqrt (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  qau_pkg::side_t                        side_in,
    input  logic [qau_pkg::RAD_W-1:0]             rad,
    output qau_pkg::side_t                        side_out,
    output logic [qau_pkg::ROOT_W-1:0]            root
);
    import qau_pkg::*;

    side_t              side_reg [ROOT_W];
    logic [RAD_W-1:0]   rad_reg  [ROOT_W];
    logic [ROOT_W-1:0]  root_reg [ROOT_W];
    logic [REM_W-1:0]   rem_reg  [ROOT_W];

    genvar s;
    generate
        for (s = 0; s < ROOT_W; s++)
        begin : g_stage
            side_t             side_prev;
            logic [RAD_W-1:0]  rad_prev;
            logic [ROOT_W-1:0] root_prev;
            logic [REM_W-1:0]  rem_prev;
            logic [REM_W+1:0]  cur;
            logic [REM_W+1:0]  trial;
            logic              take;

            if (s == 0)
            begin : g_first
                assign side_prev = side_in;
                assign rad_prev  = rad;
                assign root_prev = '0;
                assign rem_prev  = '0;
            end
            else
            begin : g_next
                assign side_prev = side_reg[s-1];
                assign rad_prev  = rad_reg[s-1];
                assign root_prev = root_reg[s-1];
                assign rem_prev  = rem_reg[s-1];
            end

            // Bring down two radicand bits and try the next root bit
            assign cur   = {rem_prev, rad_prev[RAD_W-1 -: 2]};
            assign trial = (REM_W+2)'({root_prev, 2'b01});
            assign take  = cur >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[s] <= '0;
                end
                else
                begin
                    side_reg[s] <= side_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                rad_reg[s]  <= rad_prev << 2;
                root_reg[s] <= {root_prev[ROOT_W-2:0], take};
                rem_reg[s]  <= take ? REM_W'(cur - trial) : cur[REM_W-1:0];
            end
        end
    endgenerate

    assign side_out = side_reg[ROOT_W-1];
    assign root     = root_reg[ROOT_W-1];

endmodule

@@ verif/tb_quaternion_arithmetic_unit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit testbench
// Drives a table of directed requests and then random ones through the unit,
// predicts each result in the bench and compares it field by field in order.
// ----------------------------------------------------------------------------
module tb_quaternion_arithmetic_unit_core;
    import qau_pkg::*;

    localparam int LATENCY = 38;
    localparam int N_RAND  = 1350;

    typedef struct {
        logic [31:0] r[4];
        logic [31:0] scal;
        logic        unit;
        logic        ov;
    } qres_t;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] p[4];
        logic [31:0] q[4];
        logic [31:0] sc;
        logic        chk;
        qres_t       res;
    } qreq_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  req_type;
    logic [31:0] p_real, p_i, p_j, p_k, q_real, q_i, q_j, q_k, scale_factor;
    logic        unit_tolerance_we;
    logic [28:0] unit_tolerance;
    logic        done;
    logic [31:0] r_real, r_i, r_j, r_k, r_scalar;
    logic        is_unit, overflow;

    qres_t       pending_results[$];
    logic [28:0] tol_model;
    int          mismatches;
    int          results_seen;
    int          send_idle_pct;
    qreq_t       dir_table[$];

    quaternion_arithmetic_unit_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .p_real(p_real), .p_i(p_i), .p_j(p_j), .p_k(p_k),
        .q_real(q_real), .q_i(q_i), .q_j(q_j), .q_k(q_k),
        .scale_factor(scale_factor),
        .unit_tolerance_we(unit_tolerance_we), .unit_tolerance(unit_tolerance),
        .done(done), .r_real(r_real), .r_i(r_i), .r_j(r_j), .r_k(r_k),
        .r_scalar(r_scalar), .is_unit(is_unit), .overflow(overflow)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Floor of exact sum divided by 2^FRAC_BITS; 128-bit headroom
    function automatic logic signed [127:0] fshift(input logic signed [127:0] v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic logic signed [63:0] sat_to32(input logic signed [127:0] v,
                                                    inout logic ov);
        if (v > 128'sd2147483647)
        begin
            ov = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -128'sd2147483648)
        begin
            ov = 1'b1;
            return -64'sd2147483648;
        end
        return v[63:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] n);
        logic [127:0] res;
        logic [127:0] bitv;
        res = 0;
        bitv = 128'd1 << 126;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res[63:0];
    endfunction

    function automatic logic [63:0] norm_p(input logic signed [31:0] p[4]);
        logic [127:0]        s;
        logic signed [127:0] w;
        s = 0;
        for (int i = 0; i < 4; i++)
        begin
            w = p[i];
            s = s + 128'(w * w);
        end
        return root_floor(s);
    endfunction

    function automatic qres_t predict_quat(input qreq_t rq, input logic [28:0] tol);
        qres_t o;
        logic ov;
        logic signed [127:0] a[4];
        logic signed [127:0] b[4];
        logic signed [127:0] t;
        logic signed [127:0] two;
        logic signed [31:0] ps[4];
        logic [63:0] n;
        logic [63:0] one;
        logic [63:0] diff;
        ov = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            a[i] = $signed(rq.p[i]);
            b[i] = $signed(rq.q[i]);
            ps[i] = rq.p[i];
            o.r[i] = 0;
        end
        o.scal = 0;
        o.unit = 0;
        case (rq.op)
            OP_MUL:
            begin
                o.r[0] = sat_to32(fshift(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]), ov);
                o.r[1] = sat_to32(fshift(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]), ov);
                o.r[2] = sat_to32(fshift(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]), ov);
                o.r[3] = sat_to32(fshift(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]), ov);
            end
            OP_CONJ:
            begin
                o.r[0] = rq.p[0];
                for (int i = 1; i < 4; i++)
                    o.r[i] = sat_to32(-a[i], ov);
            end
            OP_SCALE:
                for (int i = 0; i < 4; i++)
                    o.r[i] = sat_to32(fshift(a[i] * $signed(rq.sc)), ov);
            OP_NORM:
                o.scal = sat_to32($signed({64'd0, norm_p(ps)}), ov);
            OP_TRACE:
                o.scal = sat_to32(2 * a[0], ov);
            OP_DIST:
            begin
                t = 2 * fshift(a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3]);
                two = 128'sd1 <<< (FRAC_BITS + 1);
                if (t <= two && t >= -two)
                    o.scal = sat_to32($signed({64'd0,
                        root_floor((128'd1 << (2*FRAC_BITS + 2)) - 128'(t * t))}), ov);
            end
            OP_UNIT:
            begin
                n = norm_p(ps);
                one = 64'd1 << FRAC_BITS;
                diff = (n >= one) ? n - one : one - n;
                o.unit = (diff < tol);
            end
            default: ;
        endcase
        o.ov = ov;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // Compare two results field by field
    task automatic compare_res(input string tag, input qres_t got, input qres_t want);
        for (int i = 0; i < 4; i++)
        begin
            if (got.r[i] !== want.r[i])
                report_mismatch($sformatf("%s r[%0d]", tag, i), got.r[i], want.r[i]);
        end
        if (got.scal !== want.scal)
            report_mismatch({tag, " r_scalar"}, got.scal, want.scal);
        if (got.unit !== want.unit)
            report_mismatch({tag, " is_unit"}, 32'(got.unit), 32'(want.unit));
        if (got.ov !== want.ov)
            report_mismatch({tag, " overflow"}, 32'(got.ov), 32'(want.ov));
    endtask

    // Compare each strobed result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            qres_t w;
            qres_t g;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result r_real", r_real, 32'd0);
            end
            else
            begin
                w = pending_results.pop_front();
                results_seen++;
                g.r[0] = r_real;
                g.r[1] = r_i;
                g.r[2] = r_j;
                g.r[3] = r_k;
                g.scal = r_scalar;
                g.unit = is_unit;
                g.ov   = overflow;
                compare_res("result", g, w);
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h1000_0000;
            3: return 32'hf000_0000;
            4: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
            5: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Random item: Q4.28 operands mixing corner values, values within +-1 and full-range words
    function automatic qreq_t rand_req();
        qreq_t rq;
        rq.op = $urandom_range(0, 20) == 0 ? 3'd7 : $urandom_range(0, 6);
        for (int i = 0; i < 4; i++)
        begin
            rq.p[i] = rand_word();
            rq.q[i] = rand_word();
        end
        if (rq.op == OP_UNIT && $urandom_range(0, 1))
        begin
            rq.p[0] = 32'h1000_0000 + $urandom_range(0, 64) - 32;
            rq.p[1] = $urandom_range(0, 2048) - 1024;
            rq.p[2] = 0;
            rq.p[3] = $urandom_range(0, 2048) - 1024;
        end
        rq.sc = rand_word();
        rq.chk = 1'b0;
        return rq;
    endfunction

    function automatic qreq_t mk(input logic [2:0] op, input logic [31:0] pv,
                                 input logic [31:0] qv, input logic [31:0] sv);
        qreq_t rq;
        rq.op = op;
        for (int i = 0; i < 4; i++)
        begin
            rq.p[i] = pv;
            rq.q[i] = qv;
            rq.res.r[i] = 0;
        end
        rq.sc = sv;
        rq.chk = 1'b0;
        rq.res.scal = 0;
        rq.res.unit = 0;
        rq.res.ov = 0;
        return rq;
    endfunction

    // Hand one item to the unit, honoring sender idle cycles
    task automatic send_item(input qreq_t rq);
        qres_t pr;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        pr = predict_quat(rq, tol_model);
        if (rq.chk)
            compare_res("table row", pr, rq.res);
        start <= 1'b1;
        req_type <= rq.op;
        p_real <= rq.p[0]; p_i <= rq.p[1]; p_j <= rq.p[2]; p_k <= rq.p[3];
        q_real <= rq.q[0]; q_i <= rq.q[1]; q_j <= rq.q[2]; q_k <= rq.q[3];
        scale_factor <= rq.sc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(pr);
    endtask

    // Drain the pipeline, then write the tolerance register
    task automatic set_tolerance(input logic [28:0] v);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        unit_tolerance_we <= 1'b1;
        unit_tolerance <= v;
        @(posedge clk);
        unit_tolerance_we <= 1'b0;
        tol_model = v;
    endtask

    initial
    begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        qreq_t rq;
        logic [28:0] tols[5];
        rst_n = 1'b0;
        start = 1'b0;
        req_type = 0;
        {p_real, p_i, p_j, p_k, q_real, q_i, q_j, q_k, scale_factor} = '0;
        unit_tolerance_we = 1'b0;
        unit_tolerance = 0;
        tol_model = 29'd1;
        mismatches = 0;
        results_seen = 0;
        send_idle_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; expected values typed in where obvious
        rq = mk(OP_MUL, 0, 0, 0); rq.chk = 1; dir_table.push_back(rq);
        rq = mk(OP_MUL, 32'h1000_0000, 32'h1000_0000, 0); dir_table.push_back(rq);
        rq = mk(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0); dir_table.push_back(rq);
        rq = mk(OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 0); dir_table.push_back(rq);
        rq = mk(OP_CONJ, 32'h8000_0000, 0, 0); rq.chk = 1;
        rq.res.r[0] = 32'h8000_0000; rq.res.r[1] = 32'h7fff_ffff;
        rq.res.r[2] = 32'h7fff_ffff; rq.res.r[3] = 32'h7fff_ffff; rq.res.ov = 1;
        dir_table.push_back(rq);
        rq = mk(OP_CONJ, 32'h7fff_ffff, 0, 0); dir_table.push_back(rq);
        rq = mk(OP_SCALE, 32'h7fff_ffff, 0, 32'h7fff_ffff); dir_table.push_back(rq);
        rq = mk(OP_SCALE, 32'h8000_0000, 0, 32'h8000_0000); dir_table.push_back(rq);
        rq = mk(OP_SCALE, 32'hffff_ffff, 0, 32'h0000_0001); dir_table.push_back(rq);
        rq = mk(OP_NORM, 32'h8000_0000, 0, 0); rq.chk = 1;
        rq.res.scal = 32'h7fff_ffff; rq.res.ov = 1; dir_table.push_back(rq);
        rq = mk(OP_NORM, 0, 0, 0); rq.chk = 1; dir_table.push_back(rq);
        rq = mk(OP_NORM, 32'h0800_0000, 0, 0); dir_table.push_back(rq);
        rq = mk(OP_TRACE, 32'h7fff_ffff, 0, 0); rq.chk = 1;
        rq.res.scal = 32'h7fff_ffff; rq.res.ov = 1; dir_table.push_back(rq);
        rq = mk(OP_TRACE, 32'h8000_0000, 0, 0); rq.chk = 1;
        rq.res.scal = 32'h8000_0000; rq.res.ov = 1; dir_table.push_back(rq);
        rq = mk(OP_DIST, 32'h7fff_ffff, 32'h7fff_ffff, 0); rq.chk = 1;
        dir_table.push_back(rq);
        rq = mk(OP_DIST, 0, 0, 0); rq.chk = 1; rq.res.scal = 32'h2000_0000;
        dir_table.push_back(rq);
        rq = mk(OP_DIST, 32'h0800_0000, 32'h0800_0000, 0); dir_table.push_back(rq);
        rq = mk(OP_UNIT, 0, 0, 0); rq.chk = 1; dir_table.push_back(rq);
        rq = mk(OP_UNIT, 32'h0800_0000, 0, 0); rq.chk = 1; rq.res.unit = 1;
        dir_table.push_back(rq);
        rq = mk(OP_UNIT, 32'h8000_0000, 0, 0); rq.chk = 1; dir_table.push_back(rq);
        rq = mk(3'd7, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff); rq.chk = 1;
        dir_table.push_back(rq);
        foreach (dir_table[n])
            send_item(dir_table[n]);

        // Random phases across tolerance settings and idle patterns
        tols = '{29'd0, 29'd268435456, 29'd64, 29'd1, 29'd5000};
        for (int ph = 0; ph < 5; ph++)
        begin
            set_tolerance(tols[ph]);
            send_idle_pct = (ph < 2) ? 6 : (ph < 4) ? 86 : 0;
            for (int n = 0; n < N_RAND / 5; n++)
                send_item(rand_req());
        end
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        $display("ran %0d results over all opcodes, five tolerance settings", results_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
